// ===== hdl/crc8rfp_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8rfp_pkg
// Shared types, codes and the byte-wise CRC-8 update for the response frame
// parser.
// ----------------------------------------------------------------------------
package crc8rfp_pkg;

    localparam int BYTE_W = 8;
    localparam int OUTCOME_W = 3;

    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;
    localparam logic [BYTE_W-1:0] MAGIC_RESET = 8'h55;
    localparam logic [BYTE_W-1:0] MAX_PAYLOAD_RESET = 8'd250;

    // configuration register indexes
    localparam logic CFG_RESPONSE_MAGIC = 1'b0;
    localparam logic CFG_MAX_PAYLOAD = 1'b1;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_OK       = 3'd0,
        OC_NO_MAGIC = 3'd1,
        OC_TOO_LONG = 3'd2,
        OC_BAD_CRC  = 3'd3,
        OC_TRUNC    = 3'd4
    } t_outcome;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last;
        t_outcome          outcome;
        logic [BYTE_W-1:0] frame_status;
        logic [BYTE_W-1:0] frame_seq;
        logic [BYTE_W-1:0] payload_length;
    } t_result;

    // msb-first crc-8 over one byte, no final xor
    function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        c = crc ^ b;
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== hdl/crc8rfp_in_reg.sv =====
// ----------------------------------------------------------------------------
// crc8rfp_in_reg
// Input register: captures one received byte and its window-end flag.
// ----------------------------------------------------------------------------
module crc8rfp_in_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [crc8rfp_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                           i_end_of_window,
    input  logic                           i_take,
    output logic                           o_valid,
    output logic [crc8rfp_pkg::BYTE_W-1:0] o_rx_byte,
    output logic                           o_end_of_window
);

    logic                           r_valid;
    logic [crc8rfp_pkg::BYTE_W-1:0] r_byte;
    logic                           r_eow;

    assign o_ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_rx_byte;
            r_eow  <= i_end_of_window;
        end
    end

    assign o_valid         = r_valid;
    assign o_rx_byte       = r_byte;
    assign o_end_of_window = r_eow;

endmodule

// ===== hdl/crc8rfp_core.sv =====
// ----------------------------------------------------------------------------
// crc8rfp_core
// Frame state machine: hunts for magic, holds the header, runs the CRC and
// forms at most one result per byte.
// ----------------------------------------------------------------------------
module crc8rfp_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_fire,
    input  logic [crc8rfp_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                           i_end_of_window,
    input  logic [crc8rfp_pkg::BYTE_W-1:0] i_magic,
    input  logic [crc8rfp_pkg::BYTE_W-1:0] i_max_payload,
    output logic                           o_res_valid,
    output crc8rfp_pkg::t_result           o_res
);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SEQ,
        PH_STATUS,
        PH_LEN,
        PH_DATA,
        PH_CRC,
        PH_DONE
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [crc8rfp_pkg::BYTE_W-1:0] r_crc, n_crc;
    logic [crc8rfp_pkg::BYTE_W-1:0] r_seq, n_seq;
    logic [crc8rfp_pkg::BYTE_W-1:0] r_status, n_status;
    logic [crc8rfp_pkg::BYTE_W-1:0] r_len, n_len;
    logic [crc8rfp_pkg::BYTE_W-1:0] r_left, n_left;

    logic [crc8rfp_pkg::BYTE_W-1:0] crc_upd;
    logic                           emit;
    logic                           clear;
    logic                           is_last;
    crc8rfp_pkg::t_outcome          oc;
    logic [crc8rfp_pkg::BYTE_W-1:0] data_out;

    assign crc_upd = crc8rfp_pkg::crc8_byte(r_crc, i_rx_byte);

    always_comb begin
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_seq    = r_seq;
        n_status = r_status;
        n_len    = r_len;
        n_left   = r_left;
        emit     = 1'b0;
        clear    = 1'b0;
        is_last  = 1'b1;
        oc       = crc8rfp_pkg::OC_OK;
        data_out = '0;

        unique case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == i_magic) begin
                    n_seq    = '0;
                    n_status = '0;
                    n_len    = '0;
                    n_left   = '0;
                    n_crc    = crc8rfp_pkg::crc8_byte(crc8rfp_pkg::CRC_INIT, i_rx_byte);
                    n_phase  = PH_SEQ;
                    if (i_end_of_window) begin
                        emit = 1'b1;
                        oc   = crc8rfp_pkg::OC_TRUNC;
                    end
                end else if (i_end_of_window) begin
                    emit = 1'b1;
                    oc   = crc8rfp_pkg::OC_NO_MAGIC;
                end
            end
            PH_SEQ: begin
                n_seq   = i_rx_byte;
                n_crc   = crc_upd;
                n_phase = PH_STATUS;
                if (i_end_of_window) begin
                    emit = 1'b1;
                    oc   = crc8rfp_pkg::OC_TRUNC;
                end
            end
            PH_STATUS: begin
                n_status = i_rx_byte;
                n_crc    = crc_upd;
                n_phase  = PH_LEN;
                if (i_end_of_window) begin
                    emit = 1'b1;
                    oc   = crc8rfp_pkg::OC_TRUNC;
                end
            end
            PH_LEN: begin
                n_len = i_rx_byte;
                n_crc = crc_upd;
                if (i_rx_byte > i_max_payload) begin
                    // length error wins over truncation
                    emit    = 1'b1;
                    oc      = crc8rfp_pkg::OC_TOO_LONG;
                    n_phase = PH_DONE;
                end else begin
                    n_left  = i_rx_byte;
                    n_phase = (i_rx_byte != '0) ? PH_DATA : PH_CRC;
                    if (i_end_of_window) begin
                        emit = 1'b1;
                        oc   = crc8rfp_pkg::OC_TRUNC;
                    end
                end
            end
            PH_DATA: begin
                emit = 1'b1;
                if (i_end_of_window) begin
                    oc = crc8rfp_pkg::OC_TRUNC;
                end else begin
                    is_last  = 1'b0;
                    data_out = i_rx_byte;
                    n_crc    = crc_upd;
                    n_left   = r_left - 1'b1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_CRC;
                    end
                end
            end
            PH_CRC: begin
                emit    = 1'b1;
                oc      = (i_rx_byte == r_crc) ? crc8rfp_pkg::OC_OK
                                               : crc8rfp_pkg::OC_BAD_CRC;
                n_phase = PH_DONE;
            end
            PH_DONE: begin
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        // every window end returns to hunting with a clean frame
        if (i_end_of_window) begin
            clear = 1'b1;
        end
    end

    always_comb begin
        o_res_valid          = emit;
        o_res.data_byte      = data_out;
        o_res.last           = is_last;
        o_res.outcome        = oc;
        o_res.frame_status   = n_status;
        o_res.frame_seq      = n_seq;
        o_res.payload_length = n_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_crc    <= crc8rfp_pkg::CRC_INIT;
            r_seq    <= '0;
            r_status <= '0;
            r_len    <= '0;
            r_left   <= '0;
        end else if (i_fire) begin
            if (clear) begin
                r_phase  <= PH_HUNT;
                r_crc    <= crc8rfp_pkg::CRC_INIT;
                r_seq    <= '0;
                r_status <= '0;
                r_len    <= '0;
                r_left   <= '0;
            end else begin
                r_phase  <= n_phase;
                r_crc    <= n_crc;
                r_seq    <= n_seq;
                r_status <= n_status;
                r_len    <= n_len;
                r_left   <= n_left;
            end
        end
    end

endmodule

// ===== hdl/crc8rfp_out_reg.sv =====
// ----------------------------------------------------------------------------
// crc8rfp_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module crc8rfp_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  crc8rfp_pkg::t_result i_res,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output crc8rfp_pkg::t_result o_res
);

    logic                 r_valid;
    crc8rfp_pkg::t_result r_res;

    // free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ===== hdl/crc8_response_frame_parser.sv =====
// ----------------------------------------------------------------------------
// crc8_response_frame_parser
// Response frame deframer with CRC-8 check over magic, header and payload.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle and sustains one byte per cycle with no
// bubbles while the consumer keeps taking results. Each byte passes an
// input register, the frame state machine with byte-wide CRC-8 updates
// and a result register. The result register loads when the input register
// passes its byte on, which waits while the result register holds an untaken result.
// A payload byte gives a data result unless it ends the window, each frame
// ends with one report (last high), and bytes after a report are dropped
// until the window end. Configuration writes take effect on the next byte
// that uses them and belong only to idle periods.
module crc8_response_frame_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_window,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_byte,
    output logic       o_last,
    output logic [2:0] o_outcome,
    output logic [7:0] o_frame_status,
    output logic [7:0] o_frame_seq,
    output logic [7:0] o_payload_length,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [crc8rfp_pkg::BYTE_W-1:0] r_magic;
    logic [crc8rfp_pkg::BYTE_W-1:0] r_max_payload;

    logic                           in_valid;
    logic [crc8rfp_pkg::BYTE_W-1:0] in_byte;
    logic                           in_eow;
    logic                           out_free;
    logic                           fire;
    logic                           res_valid;
    crc8rfp_pkg::t_result           res;
    crc8rfp_pkg::t_result           out_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic       <= crc8rfp_pkg::MAGIC_RESET;
            r_max_payload <= crc8rfp_pkg::MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                crc8rfp_pkg::CFG_RESPONSE_MAGIC: r_magic       <= i_cfg_data;
                crc8rfp_pkg::CFG_MAX_PAYLOAD:    r_max_payload <= i_cfg_data;
                default:                         r_magic       <= r_magic;
            endcase
        end
    end

    // a byte moves on when the result register can take whatever it yields
    assign fire = in_valid && out_free;

    crc8rfp_in_reg u_in_reg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_end_of_window (i_end_of_window),
        .i_take          (fire),
        .o_valid         (in_valid),
        .o_rx_byte       (in_byte),
        .o_end_of_window (in_eow)
    );

    crc8rfp_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_rx_byte       (in_byte),
        .i_end_of_window (in_eow),
        .i_magic         (r_magic),
        .i_max_payload   (r_max_payload),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    crc8rfp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && res_valid),
        .i_res   (res),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_data_byte      = out_res.data_byte;
    assign o_last           = out_res.last;
    assign o_outcome        = out_res.outcome;
    assign o_frame_status   = out_res.frame_status;
    assign o_frame_seq      = out_res.frame_seq;
    assign o_payload_length = out_res.payload_length;

endmodule
